### rtl/core/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types for the rectangle claim table: opcodes, rectangle layout,
// controller states and the scan status bundle.
// ----------------------------------------------------------------------------
package rct_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_RESERVE = 3'd1,
    OP_BAND    = 3'd2,
    OP_CLAIM   = 3'd3,
    OP_QUERY   = 3'd4
  } opcode_t;

  // x sits in the lowest bits, matching the stream data layout
  typedef struct packed {
    logic signed [15:0] h;
    logic signed [15:0] w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } rect_t;

  localparam int unsigned RECT_BITS = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } scan_stat_t;

endpackage

### rtl/core/rct_mem.sv
// ----------------------------------------------------------------------------
// rct_mem
// Single-port-write, single-port-read rectangle store with registered read.
// ----------------------------------------------------------------------------
module rct_mem #(
  parameter int DEPTH = 96,
  parameter int WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/rct_scan.sv
// ----------------------------------------------------------------------------
// rct_scan
// Walks the stored rectangles one read per cycle and flags any overlap with
// the rectangle under test.
// ----------------------------------------------------------------------------
module rct_scan #(
  parameter int CAPACITY = 96
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [$clog2(CAPACITY+1)-1:0]  count,
  input  rct_pkg::rect_t                 probe,
  output logic                           rd_en,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
  input  logic [rct_pkg::RECT_BITS-1:0]  rd_data,
  output rct_pkg::scan_stat_t            stat
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic          active_r, active_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic          hit_r, hit_nxt;
  logic          issue;
  logic          done;
  logic          overlap;

  rct_pkg::rect_t ent;
  logic signed [16:0] e_x, e_y, e_r, e_b;
  logic signed [16:0] p_x, p_y, p_r, p_b;

  // half-open overlap test, edges summed at 17 bits so nothing wraps
  always_comb begin
    ent     = rct_pkg::rect_t'(rd_data);
    e_x     = {ent.x[15], ent.x};
    e_y     = {ent.y[15], ent.y};
    e_r     = e_x + {ent.w[15], ent.w};
    e_b     = e_y + {ent.h[15], ent.h};
    p_x     = {probe.x[15], probe.x};
    p_y     = {probe.y[15], probe.y};
    p_r     = p_x + {probe.w[15], probe.w};
    p_b     = p_y + {probe.h[15], probe.h};
    overlap = !((e_r <= p_x) || (p_r <= e_x) || (e_b <= p_y) || (p_b <= e_y));
  end

  always_comb begin
    issue      = active_r && (idx_r < count);
    done       = active_r && !issue && !pend_r;
    active_nxt = active_r;
    idx_nxt    = idx_r;
    pend_nxt   = issue;
    hit_nxt    = hit_r;
    if (pend_r && overlap) begin
      hit_nxt = 1'b1;
    end
    if (issue) begin
      idx_nxt = idx_r + CW'(1);
    end
    if (done) begin
      active_nxt = 1'b0;
    end
    if (start) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
      pend_nxt   = 1'b0;
      hit_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
      pend_r   <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      pend_r   <= pend_nxt;
      hit_r    <= hit_nxt;
    end
  end

  assign rd_en     = issue;
  assign rd_addr   = idx_r[AW-1:0];
  assign stat.busy = active_r;
  assign stat.done = done;
  assign stat.hit  = hit_r;

endmodule

### rtl/core/rectangle_claim_table.sv
// ----------------------------------------------------------------------------
// rectangle_claim_table
// Axis-aligned rectangle overlap table with clear, reserve, band, claim and query.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Clear, reserve and band items go
// straight to the finish state on acceptance. Claim and query items read
// every stored rectangle through the single read port of the store, one
// entry per cycle, before they reach the finish state.
// One item is in progress at a time; a finished result sits in an output
// register so the next item can be accepted while it waits. screen_width may
// only be written while no item is in progress.
module rectangle_claim_table #(
  parameter int CAPACITY = 96
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data,     // screen_width
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // rect_x, rect_y, rect_w, rect_h
  input  logic [2:0]  in_tuser,     // opcode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata     // ok, entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  rct_pkg::state_t     state_r, state_nxt;
  rct_pkg::opcode_t    op_r;
  rct_pkg::rect_t      rect_r;
  rct_pkg::rect_t      store_rect;
  rct_pkg::scan_stat_t scan_stat;

  logic [14:0]   sw_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r;
  logic          ok_r, ok_nxt;
  logic [6:0]    out_cnt_r;

  logic          in_fire;
  logic          scan_start;
  logic          out_free;
  logic          commit;
  logic          room;
  logic          rect_live;
  logic          band_live;
  logic          do_store;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [rct_pkg::RECT_BITS-1:0] rd_data;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == rct_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign scan_start = in_fire && ((in_tuser == rct_pkg::OP_CLAIM) ||
                                  (in_tuser == rct_pkg::OP_QUERY));
  assign out_free   = !out_valid_r || out_tready;
  assign commit     = (state_r == rct_pkg::ST_FIN) && out_free;

  always_comb begin
    room       = cnt_r < CW'(CAPACITY);
    rect_live  = (rect_r.w > 16'sd0) && (rect_r.h > 16'sd0);
    band_live  = (sw_r != 15'd0) && (rect_r.h > 16'sd0);
    store_rect = rect_r;
    do_store   = 1'b0;
    ok_nxt     = 1'b0;
    cnt_nxt    = cnt_r;
    case (op_r)
      rct_pkg::OP_CLEAR: begin
        ok_nxt  = 1'b1;
        cnt_nxt = '0;
      end
      rct_pkg::OP_RESERVE: begin
        do_store = room && rect_live;
      end
      rct_pkg::OP_BAND: begin
        store_rect.x = '0;
        store_rect.w = {1'b0, sw_r};
        do_store     = room && band_live;
      end
      rct_pkg::OP_CLAIM: begin
        do_store = room && rect_live && !scan_stat.hit;
      end
      rct_pkg::OP_QUERY: begin
        ok_nxt = !rect_live || !scan_stat.hit;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
    if (do_store) begin
      ok_nxt  = 1'b1;
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rct_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = scan_start ? rct_pkg::ST_SCAN : rct_pkg::ST_FIN;
        end
      end
      rct_pkg::ST_SCAN: begin
        if (scan_stat.done) begin
          state_nxt = rct_pkg::ST_FIN;
        end
      end
      rct_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = rct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rct_pkg::ST_IDLE;
      sw_r        <= 15'd480;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        sw_r <= cfg_data;
      end
      if (commit) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= rct_pkg::opcode_t'(in_tuser);
      rect_r <= rct_pkg::rect_t'(in_tdata);
    end
    if (commit) begin
      ok_r      <= ok_nxt;
      out_cnt_r <= 7'(cnt_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, ok_r};

  rct_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .count   (cnt_r),
    .probe   (rect_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .stat    (scan_stat)
  );

  rct_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (rct_pkg::RECT_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (commit && do_store),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (store_rect),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // checks
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_store_room : assert property (@(posedge clk) disable iff (!rst_n)
    (commit && do_store) |-> (cnt_r < CW'(CAPACITY)))
    else $error("store into a full table");

  a_idle_no_scan : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !scan_stat.busy)
    else $error("scan still running while accepting");

  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (op_r == rct_pkg::OP_CLEAR)) |=> (cnt_r == '0))
    else $error("clear left entries behind");

endmodule
